FILE: sv/tcc_pkg.sv
// -----------------------------------------------------------------------------
// Text console cursor package
// Shared types, codes and constants of the console cursor engine.
// -----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] REG_ENABLED = 2'd0;
   localparam logic [1:0] REG_COLUMNS = 2'd1;
   localparam logic [1:0] REG_ROWS    = 2'd2;

   localparam int CSR_DATA_W = 7;

   // Command codes on the request channel.
   localparam logic [1:0] ACT_CHAR = 2'd0;
   localparam logic [1:0] ACT_SET  = 2'd1;
   localparam logic [1:0] ACT_CLS  = 2'd2;

   // Result kinds on the response channel.
   localparam logic [1:0] KIND_PUT       = 2'd0;
   localparam logic [1:0] KIND_CLEAR_ROW = 2'd1;
   localparam logic [1:0] KIND_CLS       = 2'd2;

   // Control characters.
   localparam logic [7:0] CODE_TAB = 8'd9;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_CR  = 8'd13;

   localparam logic [6:0] MAX_COLUMNS   = 7'd64;
   localparam logic [5:0] MAX_ROWS      = 6'd32;
   localparam logic [6:0] RESET_COLUMNS = 7'd40;
   localparam logic [5:0] RESET_ROWS    = 6'd25;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       enabled;
      logic [6:0] columns;
      logic [5:0] rows;
   } cfg_type;

   // Operation handed from the front end to the back end.
   typedef enum logic [1:0] {
      OP_PUT,
      OP_CLEAR_ROW,
      OP_PUT_CLEAR,
      OP_CLS
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] col;
      logic [4:0] row;
      logic [7:0] glyph;
      logic [4:0] clr_row;
   } work_type;

endpackage

`default_nettype wire

FILE: sv/tcc_req_if.sv
// -----------------------------------------------------------------------------
// Console command channel
// Valid/ready channel carrying one console command per beat.
// -----------------------------------------------------------------------------
`default_nettype none

interface tcc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] char_code;
   logic [5:0] new_col;
   logic [4:0] new_row;

   modport source (output valid, action, char_code, new_col, new_row, input ready);
   modport sink   (input valid, action, char_code, new_col, new_row, output ready);
endinterface

`default_nettype wire

FILE: sv/tcc_rsp_if.sv
// -----------------------------------------------------------------------------
// Console drawing request channel
// Valid/ready channel carrying one drawing request per beat.
// -----------------------------------------------------------------------------
`default_nettype none

interface tcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [5:0] col;
   logic [4:0] row;
   logic [7:0] glyph;
   logic       last;

   modport source (output valid, kind, col, row, glyph, last, input ready);
   modport sink   (input valid, kind, col, row, glyph, last, output ready);
endinterface

`default_nettype wire

FILE: sv/tcc_front.sv
// -----------------------------------------------------------------------------
// Console cursor front end
// Accepts commands, updates the cursor and posts drawing work to the queue.
// -----------------------------------------------------------------------------
`default_nettype none

module tcc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tcc_pkg::cfg_type cfg,
   tcc_req_if.sink               req,
   input  wire logic             queue_full,
   output logic                  push,
   output tcc_pkg::work_type     push_work
);

   logic [5:0] col_ff, col_in;
   logic [4:0] row_ff, row_in;
   logic [6:0] eff_cols;
   logic [5:0] eff_rows;
   logic [6:0] col_inc;
   logic [6:0] tab_col;
   logic [5:0] row_inc;
   logic [4:0] nl_row;
   logic       accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;

   // Oversized limits behave as the screen maximum.
   assign eff_cols = (cfg.columns > tcc_pkg::MAX_COLUMNS) ? tcc_pkg::MAX_COLUMNS : cfg.columns;
   assign eff_rows = (cfg.rows > tcc_pkg::MAX_ROWS) ? tcc_pkg::MAX_ROWS : cfg.rows;

   assign col_inc = {1'b0, col_ff} + 7'd1;
   assign tab_col = ({1'b0, col_ff} + 7'd4) & 7'b111_1100;
   assign row_inc = {1'b0, row_ff} + 6'd1;
   assign nl_row  = (row_inc >= eff_rows) ? 5'd0 : row_inc[4:0];

   always_comb begin
      col_in            = col_ff;
      row_in            = row_ff;
      push              = 1'b0;
      push_work.op      = tcc_pkg::OP_PUT;
      push_work.col     = col_ff;
      push_work.row     = row_ff;
      push_work.glyph   = req.char_code;
      push_work.clr_row = nl_row;
      if (accept) begin
         case (req.action)
            tcc_pkg::ACT_SET: begin
               if ({1'b0, req.new_col} < eff_cols) col_in = req.new_col;
               if ({1'b0, req.new_row} < eff_rows) row_in = req.new_row;
            end
            tcc_pkg::ACT_CLS: begin
               col_in       = 6'd0;
               row_in       = 5'd0;
               push         = 1'b1;
               push_work.op = tcc_pkg::OP_CLS;
            end
            tcc_pkg::ACT_CHAR: begin
               if (cfg.enabled) begin
                  case (req.char_code)
                     tcc_pkg::CODE_CR: begin
                        col_in = 6'd0;
                     end
                     tcc_pkg::CODE_LF: begin
                        col_in       = 6'd0;
                        row_in       = nl_row;
                        push         = 1'b1;
                        push_work.op = tcc_pkg::OP_CLEAR_ROW;
                     end
                     tcc_pkg::CODE_TAB: begin
                        if (tab_col >= eff_cols) begin
                           col_in       = 6'd0;
                           row_in       = nl_row;
                           push         = 1'b1;
                           push_work.op = tcc_pkg::OP_CLEAR_ROW;
                        end else begin
                           col_in = tab_col[5:0];
                        end
                     end
                     default: begin
                        push = 1'b1;
                        if (col_inc >= eff_cols) begin
                           col_in       = 6'd0;
                           row_in       = nl_row;
                           push_work.op = tcc_pkg::OP_PUT_CLEAR;
                        end else begin
                           col_in = col_inc[5:0];
                        end
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 6'd0;
         row_ff <= 5'd0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/tcc_queue.sv
// -----------------------------------------------------------------------------
// Console work queue
// Small first-in first-out store between the front end and the back end.
// -----------------------------------------------------------------------------
`default_nettype none

module tcc_queue #(
   parameter int Depth = tcc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tcc_pkg::work_type push_work,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output tcc_pkg::work_type      head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   tcc_pkg::work_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_work;
   end

endmodule

`default_nettype wire

FILE: sv/tcc_back.sv
// -----------------------------------------------------------------------------
// Console cursor back end
// Expands queued work into drawing request beats behind an output register.
// -----------------------------------------------------------------------------
`default_nettype none

module tcc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              empty,
   input  wire tcc_pkg::work_type head,
   output logic                   pop,
   tcc_rsp_if.source              rsp
);

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic [1:0] kind_ff, kind_in;
   logic [5:0] col_ff, col_in;
   logic [4:0] row_ff, row_in;
   logic [7:0] glyph_ff, glyph_in;
   logic       last_ff, last_in;
   logic       load;

   // The output register may take a new beat when empty or being drained.
   assign load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff && !rsp.ready;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      glyph_in = glyph_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load && !empty) begin
         valid_in = 1'b1;
         col_in   = 6'd0;
         row_in   = 5'd0;
         glyph_in = 8'd0;
         last_in  = 1'b1;
         case (head.op)
            tcc_pkg::OP_PUT: begin
               kind_in  = tcc_pkg::KIND_PUT;
               col_in   = head.col;
               row_in   = head.row;
               glyph_in = head.glyph;
               pop      = 1'b1;
            end
            tcc_pkg::OP_CLEAR_ROW: begin
               kind_in = tcc_pkg::KIND_CLEAR_ROW;
               row_in  = head.clr_row;
               pop     = 1'b1;
            end
            tcc_pkg::OP_PUT_CLEAR: begin
               if (!phase_ff) begin
                  kind_in  = tcc_pkg::KIND_PUT;
                  col_in   = head.col;
                  row_in   = head.row;
                  glyph_in = head.glyph;
                  last_in  = 1'b0;
                  phase_in = 1'b1;
               end else begin
                  kind_in  = tcc_pkg::KIND_CLEAR_ROW;
                  row_in   = head.clr_row;
                  phase_in = 1'b0;
                  pop      = 1'b1;
               end
            end
            default: begin
               kind_in = tcc_pkg::KIND_CLS;
               pop     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      glyph_ff <= glyph_in;
      last_ff  <= last_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.kind  = kind_ff;
   assign rsp.col   = col_ff;
   assign rsp.row   = row_ff;
   assign rsp.glyph = glyph_ff;
   assign rsp.last  = last_ff;

endmodule

`default_nettype wire

FILE: sv/text_console_cursor_top.sv
// -----------------------------------------------------------------------------
// Text console cursor engine
// Turns a stream of console commands into put-character, clear-row and
// clear-screen drawing requests while tracking the cursor position.
// -----------------------------------------------------------------------------
// The engine accepts one command beat per clock cycle on the request channel
// and updates the cursor in the same cycle, so commands may follow each other
// without gaps. Each command produces zero, one or two drawing beats, which
// pass through a small work queue to the back end and leave from a registered
// output stage; the final beat of each command carries last. The first beat of
// a command is written into the work queue when the command is accepted and is
// then loaded into the output register before it can be taken. The sustained
// rate is one command per cycle while commands yield at most one beat and the
// consumer is ready; a printable character that wraps the line yields two beats,
// and the single output register issues at most one beat per cycle. The request channel
// stalls whenever the work queue is full. This happens when the consumer holds
// off the response channel, and also during a long run of line-wrapping
// characters, which need two output beats each. Configuration registers
// (enable, columns, rows) are written through the csr port and should only be
// changed while the engine is idle.
// -----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_top #(
   parameter int QueueDepth = tcc_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tcc_req_if.sink                              req,
   tcc_rsp_if.source                            rsp,
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [tcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tcc_pkg::cfg_type  cfg_ff, cfg_in;
   tcc_pkg::work_type push_work;
   tcc_pkg::work_type head;
   logic              push, pop, full, empty;

   // Register writes: each field takes the low bits of the write data.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tcc_pkg::REG_ENABLED: cfg_in.enabled = csr_wdata[0];
            tcc_pkg::REG_COLUMNS: cfg_in.columns = csr_wdata[6:0];
            tcc_pkg::REG_ROWS:    cfg_in.rows    = csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled <= 1'b0;
         cfg_ff.columns <= tcc_pkg::RESET_COLUMNS;
         cfg_ff.rows    <= tcc_pkg::RESET_ROWS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accepts commands and owns the cursor.
   tcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .queue_full (full),
      .push       (push),
      .push_work  (push_work)
   );

   // Work queue decoupling the two halves.
   tcc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   // Back end: expands work into response beats.
   tcc_back u_back (
      .clock (clock),
      .reset (reset),
      .empty (empty),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire
